// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define KRLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define KRLT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/krlt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed record lock table package
// Shared constants, codes and the record type.
// ----------------------------------------------------------------------------
package krlt_pkg;

    localparam int          DEPTH_DEF    = 64;
    localparam logic [23:0] MAX_SIZE_DEF = 24'd10485760;
    localparam int          KEY_W        = 256;
    localparam int          CAP_W        = 7;
    localparam logic [6:0]  CAP_RESET    = 7'd64;

    localparam logic [2:0] OP_OPEN_RD  = 3'd0;
    localparam logic [2:0] OP_OPEN_WR  = 3'd1;
    localparam logic [2:0] OP_CLOSE_RD = 3'd2;
    localparam logic [2:0] OP_CLOSE_WR = 3'd3;
    localparam logic [2:0] OP_SET_LEN  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_WLOCK     = 3'd3;
    localparam logic [2:0] ST_UNDERFLOW = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;
    localparam logic [2:0] ST_READERS   = 3'd6;

    typedef struct packed {
        logic [15:0] readers;
        logic        writer;
        logic [23:0] length;
    } t_rec;

endpackage

// ===== design/krlt_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module krlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== design/keyed_record_lock_table.sv =====
// ----------------------------------------------------------------------------
// Keyed record lock table
// Record table keyed by 256-bit keys with reader and writer lock accounting.
// ----------------------------------------------------------------------------
// One transaction at a time is processed. The key is found by a linear scan of
// the filled slots through the key RAM read port, one slot per cycle. After the
// scan, a found key goes through S_FETCH to read its record, then S_EXEC writes
// the result register; the next input transaction is accepted once the block
// is back in S_IDLE. A removal that moves the last record into the freed slot
// passes through S_MVRD and S_MVWR before returning to idle. An unknown op
// skips the scan and gives an OK result with zero fields from S_UNK. A result
// that is still waiting on the output holds the final step until it is taken.
// Keys and records live in RAM that is undefined until written; no clearing
// pass is needed.
module keyed_record_lock_table
    import krlt_pkg::*;
#(
    parameter int          DEPTH         = DEPTH_DEF,
    parameter logic [23:0] MAX_DATA_SIZE = MAX_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_word0..key_word3, create_flag, truncate_flag, size_value, balance_is_zero
    input  logic [287:0] s_axis_tdata,
    // op
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // entry_index, data_length, removed
    output logic [31:0]  m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [6:0]   i_cfg_data
);
`include "assert_macros.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MVRD  = 3'd4;
    localparam logic [2:0] S_MVWR  = 3'd5;
    localparam logic [2:0] S_UNK   = 3'd6;

    logic [2:0]       r_state;
    logic [CW-1:0]    r_count;
    logic [15:0]      r_rho;
    logic [15:0]      r_who;
    logic [6:0]       r_cap;
    logic [2:0]       r_op;
    logic [KEY_W-1:0] r_key;
    logic             r_create, r_trunc, r_bz;
    logic [23:0]      r_size;
    logic [CW-1:0]    r_scan;
    logic             r_pv, r_first, r_found;
    logic [IW-1:0]    r_pidx, r_idx, r_last;
    logic             r_ov;
    logic [2:0]       r_ost;
    logic [5:0]       r_oidx;
    logic [23:0]      r_olen;
    logic             r_orem;

    logic [KEY_W-1:0] key_q;
    t_rec             rec_q;
    logic             key_we, key_re, rec_we, rec_re;
    logic [IW-1:0]    key_wa, key_ra, rec_wa, rec_ra;
    logic [KEY_W-1:0] key_wd;
    t_rec             rec_wd;

    logic          s_acc, out_free, full;
    logic          n_ov;
    logic [2:0]    n_st;
    logic [IW-1:0] n_idx;
    logic [23:0]   n_len;
    logic          n_rem;
    logic [15:0]   n_rho, n_who;
    logic [CW-1:0] n_count;
    logic          n_move;
    logic [23:0]   cur_len;

    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_ov || m_axis_tready;
    assign n_ov          = (r_state == S_EXEC) || (r_state == S_UNK) || (r_ov && !m_axis_tready);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_ost;
    assign m_axis_tdata  = {1'b0, r_orem, r_olen, r_oidx};
    assign full          = (LW'(r_count) >= LW'(r_cap)) || (LW'(r_count) >= LW'(DEPTH));
    assign cur_len       = r_found ? rec_q.length : 24'd0;

    krlt_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa), .i_wdata(key_wd),
        .i_re(key_re), .i_raddr(key_ra), .o_rdata(key_q)
    );

    krlt_ram #(.WIDTH($bits(t_rec)), .DEPTH(DEPTH)) u_rec_ram (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(rec_wa), .i_wdata(rec_wd),
        .i_re(rec_re), .i_raddr(rec_ra), .o_rdata(rec_q)
    );

    always_comb begin
        key_re = (r_state == S_SCAN) || (r_state == S_MVRD);
        key_ra = (r_state == S_MVRD) ? r_last : IW'(r_scan);
        rec_re = (r_state == S_FETCH) || (r_state == S_MVRD);
        rec_ra = (r_state == S_MVRD) ? r_last : r_idx;
        key_we = 1'b0;
        key_wa = r_idx;
        key_wd = r_key;
        rec_we = 1'b0;
        rec_wa = r_idx;
        rec_wd = rec_q;
        n_st    = ST_OK;
        n_idx   = r_found ? r_idx : '0;
        n_len   = cur_len;
        n_rem   = 1'b0;
        n_rho   = r_rho;
        n_who   = r_who;
        n_count = r_count;
        n_move  = 1'b0;
        if (r_state == S_MVWR) begin
            key_we = 1'b1;
            key_wd = key_q;
            rec_we = 1'b1;
        end
        if (r_state == S_EXEC && out_free) begin
            unique case (r_op)
                OP_OPEN_RD: begin
                    if (!r_found) begin
                        n_st = ST_NOT_FOUND;
                    end else if (rec_q.writer) begin
                        n_st = ST_WLOCK;
                    end else begin
                        rec_we         = 1'b1;
                        rec_wd.readers = rec_q.readers + 16'd1;
                        n_rho          = r_rho + 16'd1;
                    end
                end
                OP_OPEN_WR: begin
                    if (r_size > MAX_DATA_SIZE) begin
                        n_st = ST_TOO_LARGE;
                    end else if (!r_found && !r_create) begin
                        n_st = ST_NOT_FOUND;
                    end else if (!r_found && full) begin
                        n_st = ST_FULL;
                        n_len = 24'd0;
                    end else begin
                        if (!r_found) begin
                            n_idx   = IW'(r_count);
                            key_we  = 1'b1;
                            key_wa  = IW'(r_count);
                            n_count = r_count + 1'b1;
                        end
                        if (r_trunc) begin
                            n_len = 24'd0;
                        end
                        rec_we         = 1'b1;
                        rec_wa         = n_idx;
                        rec_wd.readers = 16'd0;
                        rec_wd.writer  = 1'b1;
                        rec_wd.length  = n_len;
                        n_who          = r_who + 16'd1;
                    end
                end
                OP_CLOSE_RD: begin
                    if (!r_found) begin
                        n_st = ST_NOT_FOUND;
                    end else if (rec_q.readers == 16'd0 || r_rho == 16'd0) begin
                        n_st = ST_UNDERFLOW;
                    end else begin
                        rec_we         = 1'b1;
                        rec_wd.readers = rec_q.readers - 16'd1;
                        n_rho          = r_rho - 16'd1;
                    end
                end
                OP_CLOSE_WR: begin
                    if (!r_found) begin
                        n_st = ST_NOT_FOUND;
                    end else if (!rec_q.writer || r_who == 16'd0) begin
                        n_st = ST_UNDERFLOW;
                    end else if (r_rho != 16'd0) begin
                        n_st = ST_READERS;
                    end else begin
                        rec_we        = 1'b1;
                        rec_wd.writer = 1'b0;
                        n_who         = r_who - 16'd1;
                        if (r_bz) begin
                            n_count = r_count - 1'b1;
                            n_rem   = 1'b1;
                            n_len   = 24'd0;
                            n_move  = (IW'(n_count) != r_idx);
                        end
                    end
                end
                OP_SET_LEN: begin
                    if (!r_found) begin
                        n_st = ST_NOT_FOUND;
                    end else if (r_size > rec_q.length && r_size > MAX_DATA_SIZE) begin
                        n_st = ST_TOO_LARGE;
                    end else begin
                        rec_we        = 1'b1;
                        rec_wd.length = r_size;
                        n_len         = r_size;
                    end
                end
                default: begin
                    n_st = ST_OK;
                end
            endcase
            if (n_st == ST_NOT_FOUND) begin
                n_idx = '0;
                n_len = 24'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rho   <= '0;
            r_who   <= '0;
            r_cap   <= CAP_RESET;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cap <= i_cfg_data;
            end
            r_ov <= n_ov;
            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state <= (s_axis_tuser > OP_SET_LEN) ? S_UNK : S_SCAN;
                    end
                end
                S_UNK: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!r_first && r_pv && key_q == r_key) begin
                        r_state <= S_FETCH;
                    end else if (!r_first && !r_pv) begin
                        r_state <= S_EXEC;
                    end
                end
                S_FETCH: r_state <= S_EXEC;
                S_EXEC: begin
                    if (out_free) begin
                        r_rho   <= n_rho;
                        r_who   <= n_who;
                        r_count <= n_count;
                        r_state <= n_move ? S_MVRD : S_IDLE;
                    end
                end
                S_MVRD: r_state <= S_MVWR;
                S_MVWR: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op     <= s_axis_tuser;
            r_key    <= s_axis_tdata[255:0];
            r_create <= s_axis_tdata[256];
            r_trunc  <= s_axis_tdata[257];
            r_size   <= s_axis_tdata[281:258];
            r_bz     <= s_axis_tdata[282];
            r_scan   <= '0;
            r_pv     <= 1'b0;
            r_first  <= 1'b1;
            r_found  <= 1'b0;
        end
        if (r_state == S_SCAN) begin
            if (!r_first && r_pv && key_q == r_key) begin
                r_found <= 1'b1;
                r_idx   <= r_pidx;
            end else begin
                r_first <= 1'b0;
                r_pv    <= (r_scan < r_count);
                r_pidx  <= IW'(r_scan);
                if (r_scan < r_count) begin
                    r_scan <= r_scan + 1'b1;
                end
            end
        end
        if (r_state == S_UNK && out_free) begin
            r_ost  <= ST_OK;
            r_oidx <= 6'd0;
            r_olen <= 24'd0;
            r_orem <= 1'b0;
        end
        if (r_state == S_EXEC && out_free) begin
            r_ost  <= n_st;
            r_oidx <= 6'(n_idx);
            r_olen <= n_len;
            r_orem <= n_rem;
            r_last <= IW'(n_count);
        end
    end

    `KRLT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `KRLT_ASSERT_NEXT(a_busy_after_take, s_acc, !s_axis_tready)
    `KRLT_ASSERT_IMP(a_count_step, r_count != $past(r_count),
        (r_count == $past(r_count) + 1'b1) || (r_count == $past(r_count) - 1'b1))

endmodule
